### src/tecp_pkg.sv
package tecp_pkg;

  localparam int IN_W = 32;
  localparam int OUT_W = 48;
  // quotient magnitude bits below the saturation point
  localparam int QBITS = OUT_W - 1;
  // c/s needs 2^49 (Q16.32 plus the halved midpoint), (c.m)/s needs 2^32
  localparam int C_SHIFT = 49;
  localparam int M_SHIFT = 32;
  // input reg + 6 plane stages + sat check + QBITS steps + output reg
  localparam int LATENCY = 1 + 6 + 1 + QBITS + 1;

  localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [IN_W-1:0] p0_x;
    logic signed [IN_W-1:0] p0_y;
    logic signed [IN_W-1:0] p0_z;
    logic signed [IN_W-1:0] p1_x;
    logic signed [IN_W-1:0] p1_y;
    logic signed [IN_W-1:0] p1_z;
    logic signed [IN_W-1:0] p2_x;
    logic signed [IN_W-1:0] p2_y;
    logic signed [IN_W-1:0] p2_z;
    logic signed [IN_W-1:0] dir_x;
    logic signed [IN_W-1:0] dir_y;
    logic signed [IN_W-1:0] dir_z;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] set0_cx;
    logic signed [OUT_W-1:0] set0_cy;
    logic signed [OUT_W-1:0] set0_cz;
    logic signed [OUT_W-1:0] set0_offset;
    logic signed [OUT_W-1:0] set1_cx;
    logic signed [OUT_W-1:0] set1_cy;
    logic signed [OUT_W-1:0] set1_cz;
    logic signed [OUT_W-1:0] set1_offset;
    logic                    set0_bad_scale;
    logic                    set1_bad_scale;
  } out_t;

endpackage

### src/tecp_plane.sv
// One coefficient set: cross product, two dot products, scale, numerators.
// Six register stages.
module tecp_plane #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld_in,
  input  logic signed [COORD_WIDTH:0]   a_i  [3],
  input  logic signed [COORD_WIDTH:0]   b_i  [3],
  input  logic signed [COORD_WIDTH:0]   pa_i [3],
  input  logic signed [COORD_WIDTH:0]   pb_i [3],
  input  logic signed [COORD_WIDTH:0]   pc_i [3],
  output logic                          vld_o,
  output logic [3*COORD_WIDTH+6:0]      den_o,
  output logic [3*COORD_WIDTH+4+tecp_pkg::M_SHIFT:0] num_o [4],
  output logic                          neg_o [4],
  output logic                          bad_o
);

  localparam int EW  = COORD_WIDTH + 1;
  localparam int CPW = 2*COORD_WIDTH + 2;   // products and cross terms
  localparam int MW  = 2*COORD_WIDTH + 3;   // split partial products
  localparam int DW  = 3*COORD_WIDTH + 5;   // dot products
  localparam int SW  = 3*COORD_WIDTH + 7;   // scale
  // holds both shifted numerators for COORD_WIDTH >= 14
  localparam int NW  = DW + tecp_pkg::M_SHIFT;

  logic [5:0] v_r;

  logic signed [CPW-1:0] p1_r  [6];
  logic signed [EW-1:0]  m1_r  [3];
  logic signed [EW-1:0]  b1_r  [3];
  logic signed [CPW-1:0] c2_r  [3];
  logic signed [EW-1:0]  m2_r  [3];
  logic signed [EW-1:0]  b2_r  [3];
  logic signed [CPW-1:0] c3_r  [3];
  logic signed [MW-1:0]  mlo_r [3];
  logic signed [MW-1:0]  mhi_r [3];
  logic signed [MW-1:0]  vlo_r [3];
  logic signed [MW-1:0]  vhi_r [3];
  logic signed [CPW-1:0] c4_r  [3];
  logic signed [DW-1:0]  tm_r  [3];
  logic signed [DW-1:0]  tv_r  [3];
  logic signed [CPW-1:0] c5_r  [3];
  logic signed [DW-1:0]  dm_r;
  logic signed [DW-1:0]  dv_r;

  logic signed [SW-1:0]  s2_nxt;
  logic [CPW-1:0]        cmag_nxt [3];
  logic [DW-1:0]         dmag_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[4:0], vld_in};
    end
  end

  // stage 1: cross partial products, midpoint sums
  always_ff @(posedge clk) begin
    p1_r[0] <= a_i[1] * b_i[2];
    p1_r[1] <= a_i[2] * b_i[1];
    p1_r[2] <= a_i[2] * b_i[0];
    p1_r[3] <= a_i[0] * b_i[2];
    p1_r[4] <= a_i[0] * b_i[1];
    p1_r[5] <= a_i[1] * b_i[0];
    for (int i = 0; i < 3; i++) begin
      m1_r[i] <= pa_i[i] + pc_i[i];
      b1_r[i] <= pb_i[i];
    end
  end

  // stage 2: cross product
  always_ff @(posedge clk) begin
    c2_r[0] <= p1_r[0] - p1_r[1];
    c2_r[1] <= p1_r[2] - p1_r[3];
    c2_r[2] <= p1_r[4] - p1_r[5];
    m2_r <= m1_r;
    b2_r <= b1_r;
  end

  // stage 3: dot-product partials, cross term split in low/high halves
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mlo_r[i] <= $signed({1'b0, c2_r[i][COORD_WIDTH:0]}) * m2_r[i];
      mhi_r[i] <= $signed(c2_r[i][CPW-1:COORD_WIDTH+1]) * m2_r[i];
      vlo_r[i] <= $signed({1'b0, c2_r[i][COORD_WIDTH:0]}) * b2_r[i];
      vhi_r[i] <= $signed(c2_r[i][CPW-1:COORD_WIDTH+1]) * b2_r[i];
    end
    c3_r <= c2_r;
  end

  // stage 4: recombine halves
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      tm_r[i] <= (DW'(mhi_r[i]) <<< (COORD_WIDTH+1)) + DW'(mlo_r[i]);
      tv_r[i] <= (DW'(vhi_r[i]) <<< (COORD_WIDTH+1)) + DW'(vlo_r[i]);
    end
    c4_r <= c3_r;
  end

  // stage 5: dot sums
  always_ff @(posedge clk) begin
    dm_r <= tm_r[0] + tm_r[1] + tm_r[2];
    dv_r <= tv_r[0] + tv_r[1] + tv_r[2];
    c5_r <= c4_r;
  end

  // stage 6: scale (doubled), numerator magnitudes
  always_comb begin
    s2_nxt = (SW'(dv_r) <<< 1) - SW'(dm_r);
    for (int i = 0; i < 3; i++) begin
      cmag_nxt[i] = c5_r[i][CPW-1] ? CPW'(-c5_r[i]) : CPW'(c5_r[i]);
    end
    dmag_nxt = dm_r[DW-1] ? DW'(-dm_r) : DW'(dm_r);
  end

  always_ff @(posedge clk) begin
    den_o <= s2_nxt;
    bad_o <= s2_nxt[SW-1] || (s2_nxt == '0);
    for (int i = 0; i < 3; i++) begin
      num_o[i] <= NW'(cmag_nxt[i]) << tecp_pkg::C_SHIFT;
      neg_o[i] <= c5_r[i][CPW-1];
    end
    num_o[3] <= NW'(dmag_nxt) << tecp_pkg::M_SHIFT;
    neg_o[3] <= dm_r[DW-1];
  end

  assign vld_o = v_r[5];

endmodule

### src/tecp_div.sv
// Four quotients over one shared scale: saturation check, then one
// restoring step per quotient bit, then sign, clamp and zeroing on a bad scale.
module tecp_div #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld_in,
  input  logic [3*COORD_WIDTH+6:0]      den_i,
  input  logic [3*COORD_WIDTH+4+tecp_pkg::M_SHIFT:0] num_i [4],
  input  logic                          neg_i [4],
  input  logic                          bad_i,
  output logic                          vld_o,
  output logic [tecp_pkg::OUT_W-1:0]    res_o [4],
  output logic                          bad_o
);

  localparam int SW = 3*COORD_WIDTH + 7;
  localparam int QB = tecp_pkg::QBITS;
  localparam int RW = SW + QB;

  logic [RW-1:0] rem_r [QB+1][4];
  logic [QB-1:0] q_r   [QB+1][4];
  logic          neg_r [QB+1][4];
  logic          sat_r [QB+1][4];
  logic [SW-2:0] den_r [QB+1];
  logic          bad_r [QB+1];
  logic [QB:0]   v_r;
  logic          vo_r;

  logic [RW-1:0] dlim;
  assign dlim = RW'(den_i[SW-2:0]) << QB;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      vo_r <= 1'b0;
    end else begin
      v_r  <= {v_r[QB-1:0], vld_in};
      vo_r <= v_r[QB];
    end
  end

  // entry: quotient too large for the output when num >= den * 2^QB
  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      rem_r[0][j] <= RW'(num_i[j]);
      q_r[0][j]   <= '0;
      neg_r[0][j] <= neg_i[j];
      sat_r[0][j] <= (RW'(num_i[j]) >= dlim);
    end
    den_r[0] <= den_i[SW-2:0];
    bad_r[0] <= bad_i;
  end

  genvar g;
  for (g = 0; g < QB; g++) begin : g_step
    localparam int K = QB - 1 - g;
    logic [RW-1:0] dsh;
    logic [RW-1:0] rem_nxt [4];
    logic [QB-1:0] q_nxt   [4];

    assign dsh = RW'(den_r[g]) << K;

    always_comb begin
      for (int j = 0; j < 4; j++) begin
        rem_nxt[j] = rem_r[g][j];
        q_nxt[j]   = q_r[g][j];
        if (rem_r[g][j] >= dsh) begin
          rem_nxt[j] = rem_r[g][j] - dsh;
          q_nxt[j][K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_r[g+1] <= rem_nxt;
      q_r[g+1]   <= q_nxt;
      neg_r[g+1] <= neg_r[g];
      sat_r[g+1] <= sat_r[g];
      den_r[g+1] <= den_r[g];
      bad_r[g+1] <= bad_r[g];
    end
  end

  logic [tecp_pkg::OUT_W-1:0] res_nxt [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      res_nxt[j] = {1'b0, q_r[QB][j]};
      if (neg_r[QB][j]) res_nxt[j] = -res_nxt[j];
      if (sat_r[QB][j]) begin
        res_nxt[j] = neg_r[QB][j] ? tecp_pkg::SAT_MIN : tecp_pkg::SAT_MAX;
      end
      if (bad_r[QB]) res_nxt[j] = '0;
    end
  end

  always_ff @(posedge clk) begin
    res_o <= res_nxt;
    bad_o <= bad_r[QB];
  end

  assign vld_o = vo_r;

endmodule

### src/triangle_edge_plane_coeffs.sv
// Channel   Ports                       Transaction
// --------  --------------------------  ------------------------------------
// input     start, busy, in_data        start high and busy low at clk edge
// result    out_strobe, out_data        out_strobe high for one cycle
//
// Fully pipelined: one triangle can enter every cycle, busy stays low.
// Each triangle passes through one input register, six setup stages (cross,
// dots, scale), one saturation check and 47 restoring-divide stages (one
// quotient bit each), then one output register. The divider depth sets the
// latency. Synchronous reset clears only the valid bits. The receiver cannot
// stall, so nothing ever backs up.
module triangle_edge_plane_coeffs #(
  parameter int COORD_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  tecp_pkg::in_t   in_data,
  output logic            out_strobe,
  output tecp_pkg::out_t  out_data
);

  localparam int EW = COORD_WIDTH + 1;

  // input stage: low COORD_WIDTH bits, sign-extended, plus edge vectors
  logic signed [EW-1:0] p0_nxt [3];
  logic signed [EW-1:0] p1_nxt [3];
  logic signed [EW-1:0] p2_nxt [3];
  logic signed [EW-1:0] d_nxt  [3];

  logic signed [EW-1:0] p0_r [3];
  logic signed [EW-1:0] p1_r [3];
  logic signed [EW-1:0] p2_r [3];
  logic signed [EW-1:0] d_r  [3];
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  logic                 vin_r;

  assign busy = 1'b0;

  always_comb begin
    p0_nxt[0] = EW'($signed(in_data.p0_x[COORD_WIDTH-1:0]));
    p0_nxt[1] = EW'($signed(in_data.p0_y[COORD_WIDTH-1:0]));
    p0_nxt[2] = EW'($signed(in_data.p0_z[COORD_WIDTH-1:0]));
    p1_nxt[0] = EW'($signed(in_data.p1_x[COORD_WIDTH-1:0]));
    p1_nxt[1] = EW'($signed(in_data.p1_y[COORD_WIDTH-1:0]));
    p1_nxt[2] = EW'($signed(in_data.p1_z[COORD_WIDTH-1:0]));
    p2_nxt[0] = EW'($signed(in_data.p2_x[COORD_WIDTH-1:0]));
    p2_nxt[1] = EW'($signed(in_data.p2_y[COORD_WIDTH-1:0]));
    p2_nxt[2] = EW'($signed(in_data.p2_z[COORD_WIDTH-1:0]));
    d_nxt[0]  = EW'($signed(in_data.dir_x[COORD_WIDTH-1:0]));
    d_nxt[1]  = EW'($signed(in_data.dir_y[COORD_WIDTH-1:0]));
    d_nxt[2]  = EW'($signed(in_data.dir_z[COORD_WIDTH-1:0]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vin_r <= 1'b0;
    end else begin
      vin_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p0_r[i] <= p0_nxt[i];
      p1_r[i] <= p1_nxt[i];
      p2_r[i] <= p2_nxt[i];
      d_r[i]  <= d_nxt[i];
      e1_r[i] <= p1_nxt[i] - p0_nxt[i];
      e2_r[i] <= p2_nxt[i] - p0_nxt[i];
    end
  end

  localparam int SW = 3*COORD_WIDTH + 7;
  localparam int NW = 3*COORD_WIDTH + 5 + tecp_pkg::M_SHIFT;

  logic          pv   [2];
  logic [SW-1:0] pden [2];
  logic [NW-1:0] pnum [2][4];
  logic          pneg [2][4];
  logic          pbad [2];

  logic                       dv   [2];
  logic [tecp_pkg::OUT_W-1:0] dres [2][4];
  logic                       dbad [2];

  // set 0: c = d x e2, midpoint p0+p2, scale point p1
  tecp_plane #(.COORD_WIDTH(COORD_WIDTH)) u_plane0 (
    .clk(clk), .rst_n(rst_n), .vld_in(vin_r),
    .a_i(d_r), .b_i(e2_r), .pa_i(p0_r), .pb_i(p1_r), .pc_i(p2_r),
    .vld_o(pv[0]), .den_o(pden[0]), .num_o(pnum[0]), .neg_o(pneg[0]),
    .bad_o(pbad[0])
  );

  // set 1: c = e1 x d, midpoint p0+p1, scale point p2
  tecp_plane #(.COORD_WIDTH(COORD_WIDTH)) u_plane1 (
    .clk(clk), .rst_n(rst_n), .vld_in(vin_r),
    .a_i(e1_r), .b_i(d_r), .pa_i(p0_r), .pb_i(p2_r), .pc_i(p1_r),
    .vld_o(pv[1]), .den_o(pden[1]), .num_o(pnum[1]), .neg_o(pneg[1]),
    .bad_o(pbad[1])
  );

  tecp_div #(.COORD_WIDTH(COORD_WIDTH)) u_div0 (
    .clk(clk), .rst_n(rst_n), .vld_in(pv[0]), .den_i(pden[0]),
    .num_i(pnum[0]), .neg_i(pneg[0]), .bad_i(pbad[0]),
    .vld_o(dv[0]), .res_o(dres[0]), .bad_o(dbad[0])
  );

  tecp_div #(.COORD_WIDTH(COORD_WIDTH)) u_div1 (
    .clk(clk), .rst_n(rst_n), .vld_in(pv[1]), .den_i(pden[1]),
    .num_i(pnum[1]), .neg_i(pneg[1]), .bad_i(pbad[1]),
    .vld_o(dv[1]), .res_o(dres[1]), .bad_o(dbad[1])
  );

  // both lanes run in lockstep
  assign out_strobe = dv[0] && dv[1];

  always_comb begin
    out_data.set0_cx        = dres[0][0];
    out_data.set0_cy        = dres[0][1];
    out_data.set0_cz        = dres[0][2];
    out_data.set0_offset    = dres[0][3];
    out_data.set1_cx        = dres[1][0];
    out_data.set1_cy        = dres[1][1];
    out_data.set1_cz        = dres[1][2];
    out_data.set1_offset    = dres[1][3];
    out_data.set0_bad_scale = dbad[0];
    out_data.set1_bad_scale = dbad[1];
  end

endmodule

### src/tecp_checker.sv
module tecp_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_strobe,
  input tecp_pkg::out_t out_data
);

  // every transaction yields one result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(tecp_pkg::LATENCY) out_strobe)
    else $error("result missing after input transaction");

  // no result without a matching transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy && rst_n, tecp_pkg::LATENCY))
    else $error("result without input transaction");

  a_bad0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.set0_bad_scale) |->
      (out_data.set0_cx == '0 && out_data.set0_cy == '0 &&
       out_data.set0_cz == '0 && out_data.set0_offset == '0))
    else $error("set 0 flagged bad but not zeroed");

  a_bad1_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.set1_bad_scale) |->
      (out_data.set1_cx == '0 && out_data.set1_cy == '0 &&
       out_data.set1_cz == '0 && out_data.set1_offset == '0))
    else $error("set 1 flagged bad but not zeroed");

endmodule

bind triangle_edge_plane_coeffs tecp_checker u_tecp_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_strobe(out_strobe), .out_data(out_data)
);

### sim/triangle_edge_plane_coeffs_test.sv
`timescale 1ns / 1ps

module triangle_edge_plane_coeffs_test;

  // wide enough for every exact intermediate (c*2^49 is well under 160 bits)
  typedef logic signed [191:0] acc_t;

  typedef struct {
    tecp_pkg::in_t  stim;
    bit             known;   // expected value typed in below
    tecp_pkg::out_t want;
  } row_t;

  localparam int N_RANDOM = 1800;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  tecp_pkg::in_t  in_data = '0;
  logic out_strobe;
  tecp_pkg::out_t out_data;

  tecp_pkg::out_t pending_coeffs[$];
  int   n_errors = 0;
  int   n_sent = 0;
  int   n_seen = 0;
  int   n_bad0 = 0;
  int   n_bad1 = 0;
  int   n_sat = 0;

  triangle_edge_plane_coeffs i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Truncated, saturated Q16.32 quotient of a signed numerator over a
  // positive scale.
  function automatic logic [tecp_pkg::OUT_W-1:0] sat_quot(acc_t num, acc_t den);
    logic [191:0] mag;
    logic [191:0] q;
    logic [191:0] nq;
    logic         neg;
    neg = num < 0;
    mag = neg ? -num : num;
    q = mag / den;
    nq = -q;
    if (q > 192'(tecp_pkg::SAT_MAX)) return neg ? tecp_pkg::SAT_MIN : tecp_pkg::SAT_MAX;
    return neg ? nq[tecp_pkg::OUT_W-1:0] : q[tecp_pkg::OUT_W-1:0];
  endfunction

  // One coefficient set: c = a x b, scale (doubled) = 2 c.pb - c.(pa + pc).
  function automatic void plane_set(input acc_t a[3], input acc_t b[3],
                                    input acc_t pa[3], input acc_t pb[3],
                                    input acc_t pc[3],
                                    output logic [tecp_pkg::OUT_W-1:0] f[4],
                                    output logic bad);
    acc_t c[3];
    acc_t dm2;
    acc_t dv;
    acc_t s2;
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
    dm2 = 0;
    dv = 0;
    for (int i = 0; i < 3; i++) begin
      dm2 += c[i] * (pa[i] + pc[i]);
      dv += c[i] * pb[i];
    end
    s2 = 2 * dv - dm2;
    bad = s2 <= 0;
    for (int i = 0; i < 4; i++) f[i] = '0;
    if (!bad) begin
      for (int i = 0; i < 3; i++) f[i] = sat_quot(c[i] <<< tecp_pkg::C_SHIFT, s2);
      f[3] = sat_quot(dm2 <<< tecp_pkg::M_SHIFT, s2);
    end
  endfunction

  function automatic tecp_pkg::out_t plane_coeffs(tecp_pkg::in_t t);
    acc_t p0[3], p1[3], p2[3], d[3], e1[3], e2[3];
    logic [tecp_pkg::OUT_W-1:0] f0[4], f1[4];
    logic b0, b1;
    tecp_pkg::out_t r;
    p0 = '{acc_t'(t.p0_x), acc_t'(t.p0_y), acc_t'(t.p0_z)};
    p1 = '{acc_t'(t.p1_x), acc_t'(t.p1_y), acc_t'(t.p1_z)};
    p2 = '{acc_t'(t.p2_x), acc_t'(t.p2_y), acc_t'(t.p2_z)};
    d  = '{acc_t'(t.dir_x), acc_t'(t.dir_y), acc_t'(t.dir_z)};
    for (int i = 0; i < 3; i++) begin
      e1[i] = p1[i] - p0[i];
      e2[i] = p2[i] - p0[i];
    end
    plane_set(d, e2, p0, p1, p2, f0, b0);
    plane_set(e1, d, p0, p2, p1, f1, b1);
    r.set0_cx = f0[0]; r.set0_cy = f0[1]; r.set0_cz = f0[2]; r.set0_offset = f0[3];
    r.set1_cx = f1[0]; r.set1_cy = f1[1]; r.set1_cz = f1[2]; r.set1_offset = f1[3];
    r.set0_bad_scale = b0;
    r.set1_bad_scale = b1;
    return r;
  endfunction

  // Coordinate by class: full 32-bit, extreme, small integer, small Q16.16.
  function automatic logic [tecp_pkg::IN_W-1:0] pick_coord(int span);
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      4:       return 32'($signed($urandom_range(0, 8)) - 4);
      default: return 32'($signed($urandom_range(0, 2 * span)) - span) <<< 16;
    endcase
  endfunction

  // Present one triangle, hold it until it is taken, queue its expectation.
  task automatic send_triangle(input tecp_pkg::in_t t, input tecp_pkg::out_t want);
    @(negedge clk);
    start <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (busy);
    pending_coeffs.push_back(want);
    n_sent++;
    if (want.set0_bad_scale) n_bad0++;
    if (want.set1_bad_scale) n_bad1++;
  endtask

  // Random gap after a transaction; start drops only when a gap is taken.
  task automatic maybe_pause(input bit allow);
    if (allow && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk);
    end
  endtask

  // Result checker: every strobe must match the oldest expectation.
  always @(posedge clk) begin
    tecp_pkg::out_t want;
    logic [tecp_pkg::OUT_W-1:0] ev[8], av[8];
    if (rst_n && out_strobe) begin
      n_seen++;
      if (pending_coeffs.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        n_errors++;
      end else begin
        want = pending_coeffs.pop_front();
        ev = '{want.set0_cx, want.set0_cy, want.set0_cz, want.set0_offset,
               want.set1_cx, want.set1_cy, want.set1_cz, want.set1_offset};
        av = '{out_data.set0_cx, out_data.set0_cy, out_data.set0_cz,
               out_data.set0_offset, out_data.set1_cx, out_data.set1_cy,
               out_data.set1_cz, out_data.set1_offset};
        for (int i = 0; i < 8; i++) begin
          if (ev[i] == tecp_pkg::SAT_MAX || ev[i] == tecp_pkg::SAT_MIN) n_sat++;
          if (av[i] !== ev[i]) begin
            $display("%0t: coeff %0d (set %0d) expected %h actual %h",
                     $time, i % 4, i / 4, ev[i], av[i]);
            n_errors++;
          end
        end
        if (out_data.set0_bad_scale !== want.set0_bad_scale) begin
          $display("%0t: set0_bad_scale expected %b actual %b",
                   $time, want.set0_bad_scale, out_data.set0_bad_scale);
          n_errors++;
        end
        if (out_data.set1_bad_scale !== want.set1_bad_scale) begin
          $display("%0t: set1_bad_scale expected %b actual %b",
                   $time, want.set1_bad_scale, out_data.set1_bad_scale);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: far beyond 1800 triangles with worst gaps plus pipeline depth.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    row_t rows[$];
    row_t r;
    tecp_pkg::out_t both_bad;
    tecp_pkg::in_t  t;
    tecp_pkg::out_t want;
    int   span;
    localparam logic [31:0] ONE = 32'h0001_0000;

    both_bad = '0;
    both_bad.set0_bad_scale = 1'b1;
    both_bad.set1_bad_scale = 1'b1;

    // all zero: no triangle at all, both scales zero
    r.stim = '0; r.known = 1; r.want = both_bad; rows.push_back(r);
    // every coordinate at the top, then the bottom: edges vanish
    r.stim = {12{32'h7fff_ffff}}; rows.push_back(r);
    r.stim = {12{32'h8000_0000}}; rows.push_back(r);
    // collinear vertices
    r.stim = '0;
    r.stim.p1_x = ONE; r.stim.p1_y = ONE; r.stim.p1_z = ONE;
    r.stim.p2_x = 2 * ONE; r.stim.p2_y = 2 * ONE; r.stim.p2_z = 2 * ONE;
    r.stim.dir_z = ONE; rows.push_back(r);
    // direction lying in the triangle's plane
    r.stim = '0;
    r.stim.p1_x = ONE; r.stim.p2_y = ONE; r.stim.dir_x = ONE; rows.push_back(r);
    // unit triangle, direction both ways along the normal
    r.known = 0;
    r.stim.dir_x = '0; r.stim.dir_z = ONE; rows.push_back(r);
    r.stim.dir_z = -ONE; rows.push_back(r);
    // nearly flat edge against a long one: quotients saturate
    r.stim = '0;
    r.stim.p2_x = 32'h7fff_ffff; r.stim.p1_y = 32'h1; r.stim.dir_z = ONE; rows.push_back(r);
    r.stim.dir_z = -ONE; rows.push_back(r);
    r.stim.p2_x = 32'h8000_0000; rows.push_back(r);
    // mixed extremes and alternating bit patterns
    r.stim = {32'h7fff_ffff, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h0,
              32'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h1};
    rows.push_back(r);
    r.stim = {6{32'haaaa_aaaa, 32'h5555_5555}}; rows.push_back(r);
    r.stim = {6{32'h5555_5555, 32'haaaa_aaaa}}; rows.push_back(r);
    r.stim = {32'h1, 32'h0, 32'hffff_ffff, 32'hffff_ffff, 32'h1, 32'h0,
              32'h0, 32'hffff_ffff, 32'h1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    rows.push_back(r);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      send_triangle(rows[i].stim, rows[i].known ? rows[i].want : plane_coeffs(rows[i].stim));
      maybe_pause(1);
    end

    // Mostly proper triangles facing the direction (both scales positive),
    // the rest raw noise or deliberately back-facing.
    for (int n = 0; n < N_RANDOM; n++) begin
      span = $urandom_range(0, 4) == 0 ? 30000 : $urandom_range(1, 64);
      if ($urandom_range(0, 4) == 0) begin
        t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end else begin
        t = {pick_coord(span), pick_coord(span), pick_coord(span),
             pick_coord(span), pick_coord(span), pick_coord(span),
             pick_coord(span), pick_coord(span), pick_coord(span),
             pick_coord(span), pick_coord(span), pick_coord(span)};
      end
      want = plane_coeffs(t);
      // both scales share the sign of d.(e2 x e1): flipping d turns it around
      if (want.set0_bad_scale && $urandom_range(0, 9) != 0 &&
          t.dir_x != 32'h8000_0000 && t.dir_y != 32'h8000_0000 &&
          t.dir_z != 32'h8000_0000) begin
        t.dir_x = -t.dir_x; t.dir_y = -t.dir_y; t.dir_z = -t.dir_z;
        want = plane_coeffs(t);
      end
      send_triangle(t, want);
      maybe_pause(n < N_RANDOM - 200);
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_coeffs.size() != 0) @(posedge clk);
    repeat (tecp_pkg::LATENCY + 10) @(posedge clk);

    $display("Sent %0d triangles, checked %0d results", n_sent, n_seen);
    $display("Bad scale: set0 %0d, set1 %0d; saturated coefficients %0d",
             n_bad0, n_bad1, n_sat);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
src/tecp_pkg.sv
src/tecp_plane.sv
src/tecp_div.sv
src/triangle_edge_plane_coeffs.sv
src/tecp_checker.sv
sim/triangle_edge_plane_coeffs_test.sv
